// ===== rtl/tss_pkg.sv =====
package tss_pkg;

    // default sizes
    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 32;

    // fixed arithmetic widths
    localparam int WIDE_BITS  = 128;
    localparam int HALF_BITS  = 64;
    localparam int TOTAL_BITS = 42;
    localparam int FRAC_BITS  = 8;
    localparam int Q_BITS     = 40;
    localparam int PCT_DENOM  = 100;
    localparam int PCT_COUNT  = 6;
    localparam int STEP_BITS  = $clog2(WIDE_BITS + 1);

    // reciprocal constants for the fixed divides of the percentile step
    localparam int          PCT_RECIP_SHIFT = 32;
    localparam logic [63:0] PCT_RECIP       = 64'd42949673;          // ceil(2^32 / 100)
    localparam int          INTERP_SHIFT    = 6;                     // 256 / 100 = 64 / 25
    localparam logic [63:0] INTERP_RECIP    = 64'd737869762948382065; // ceil(2^64 / 25)

    // operation codes
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_REPORT  = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    // result kinds
    localparam logic KIND_SUMMARY    = 1'b0;
    localparam logic KIND_PERCENTILE = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] sample_value;
    } tss_in_t;

    typedef struct packed {
        logic        item_kind;
        logic [31:0] smallest_sample;
        logic [31:0] largest_sample;
        logic [41:0] sample_total;
        logic [10:0] sample_count;
        logic [39:0] mean_value;
        logic [39:0] std_dev_value;
        logic [2:0]  percentile_slot;
        logic [39:0] percentile_value;
        logic        store_overflow;
        logic        last_item;
    } tss_out_t;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } tss_alu_op_t;

    typedef struct packed {
        logic        start;
        tss_alu_op_t op;
    } tss_alu_req_t;

    typedef struct packed {
        logic                 done;
        logic [WIDE_BITS-1:0] result;
    } tss_alu_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MEAN_WAIT,
        S_SQ_RD,
        S_SQ_DATA,
        S_SQ_WAIT,
        S_NQ_START,
        S_NQ_WAIT,
        S_SS_WAIT,
        S_VAR_START,
        S_VAR_WAIT,
        S_SQRT_WAIT,
        S_SUMMARY,
        S_SORT_RD,
        S_SORT_GET,
        S_SORT_CMP,
        S_SORT_PUT,
        S_SORT_NEXT,
        S_PCT_START,
        S_PCT_DIV,
        S_PCT_RDL,
        S_PCT_RDU,
        S_PCT_MUL,
        S_PCT_DIV2,
        S_PCT_EMIT,
        S_EMIT
    } tss_state_t;

    // percentile targets in percent
    function automatic logic [6:0] pct_target(input logic [2:0] slot);
        logic [6:0] p;
        case (slot)
            3'd0:    p = 7'd25;
            3'd1:    p = 7'd50;
            3'd2:    p = 7'd75;
            3'd3:    p = 7'd90;
            3'd4:    p = 7'd95;
            3'd5:    p = 7'd99;
            default: p = 7'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/tss_alu.sv =====
module tss_alu
    import tss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tss_alu_req_t         req,
    input  logic [WIDE_BITS-1:0] opa,
    input  logic [HALF_BITS-1:0] opb,
    output tss_alu_rsp_t         rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    tss_alu_op_t          op_reg, op_next;
    logic [STEP_BITS-1:0] cnt_reg, cnt_next;
    logic [WIDE_BITS-1:0] acc_reg, acc_next;
    logic [WIDE_BITS-1:0] x_reg, x_next;
    logic [WIDE_BITS-1:0] y_reg, y_next;
    logic [HALF_BITS-1:0] rem_reg, rem_next;
    logic [HALF_BITS-1:0] d_reg, d_next;

    logic [HALF_BITS:0]   rem_shift;
    logic                 div_ge;
    logic [HALF_BITS:0]   rem_diff;
    logic [WIDE_BITS-1:0] sq_trial;
    logic                 sq_ge;

    // restoring divide step and sqrt trial
    assign rem_shift = {rem_reg, x_reg[WIDE_BITS-1]};
    assign div_ge    = rem_shift >= {1'b0, d_reg};
    assign rem_diff  = rem_shift - {1'b0, d_reg};
    assign sq_trial  = acc_reg + y_reg;
    assign sq_ge     = x_reg >= sq_trial;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ALU_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    // one step per cycle of the selected operation
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            acc_next  = '0;
            x_next    = opa;
            rem_next  = '0;
            d_next    = opb;
            case (req.op)
                ALU_MUL:
                begin
                    y_next   = WIDE_BITS'(opb);
                    cnt_next = '0;
                end
                ALU_DIV:
                begin
                    y_next   = '0;
                    cnt_next = STEP_BITS'(WIDE_BITS);
                end
                ALU_SQRT:
                begin
                    y_next   = WIDE_BITS'(1) << (WIDE_BITS - 2);
                    cnt_next = STEP_BITS'(WIDE_BITS / 2);
                end
                default:
                begin
                    y_next   = '0;
                    cnt_next = '0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                ALU_MUL:
                begin
                    // shift-add, stops once the multiplier runs out of ones
                    if (y_reg == '0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        if (y_reg[0])
                        begin
                            acc_next = acc_reg + x_reg;
                        end
                        x_next = x_reg << 1;
                        y_next = y_reg >> 1;
                    end
                end
                ALU_DIV:
                begin
                    rem_next = div_ge ? rem_diff[HALF_BITS-1:0] : rem_shift[HALF_BITS-1:0];
                    acc_next = {acc_reg[WIDE_BITS-2:0], div_ge};
                    x_next   = x_reg << 1;
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == STEP_BITS'(1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                ALU_SQRT:
                begin
                    if (sq_ge)
                    begin
                        x_next   = x_reg - sq_trial;
                        acc_next = (acc_reg >> 1) + y_reg;
                    end
                    else
                    begin
                        acc_next = acc_reg >> 1;
                    end
                    y_next   = y_reg >> 2;
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == STEP_BITS'(1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

    // checks
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("alu started while busy");
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("alu done while still busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg || $past(req.start))
        else $error("alu done held");

endmodule

// ===== rtl/timing_sample_statistics.sv =====
// Sample statistics block. Add requests are accepted back to back; each
// updates min, max, saturating total and count and stores the sample (once
// the store is full the sample is dropped and the sticky overflow flag set).
// A clear request resets the statistics and the overflow flag. A report
// request holds in_ready low until its last result is taken: the summary
// needs a divide for the mean, one serial multiply per stored sample for the
// sum of squares, then two wide multiplies, a divide and a square root. With
// percentiles enabled the samples are insertion sorted into a buffer, one
// compare and shift per cycle, and each of the six percentiles is then
// interpolated, its divides by 100 done as reciprocal multiplies. All of
// this runs on one shared shift/add unit. No clearing pass is needed after reset.
module timing_sample_statistics
    import tss_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  tss_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output tss_out_t out_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data
);

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int PW = CW + 7;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    // sample store and sort buffer
    logic [SAMPLE_BITS-1:0] store_mem [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0] sort_mem [MAX_SAMPLES];
    logic                   store_we;
    logic [AW-1:0]          store_waddr;
    logic [SAMPLE_BITS-1:0] store_wdata;
    logic [AW-1:0]          store_raddr;
    logic [SAMPLE_BITS-1:0] store_rd_reg;
    logic                   sort_we;
    logic [AW-1:0]          sort_waddr;
    logic [SAMPLE_BITS-1:0] sort_wdata;
    logic [AW-1:0]          sort_raddr;
    logic [SAMPLE_BITS-1:0] sort_rd_reg;

    // control state
    tss_state_t             state_reg, state_next;
    tss_state_t             ret_reg, ret_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   pct_en_reg, pct_en_next;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [TOTAL_BITS-1:0]  sum_reg, sum_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   ovf_reg, ovf_next;

    // report working registers
    tss_out_t               out_reg, out_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          j_reg, j_next;
    logic [2:0]             k_reg, k_next;
    logic [WIDE_BITS-1:0]   q_reg, q_next;
    logic [HALF_BITS-1:0]   s_reg, s_next;
    logic [WIDE_BITS-1:0]   wide_reg, wide_next;
    logic [Q_BITS-1:0]      mean_reg, mean_next;
    logic [Q_BITS-1:0]      std_reg, std_next;
    logic [SAMPLE_BITS-1:0] x_reg, x_next;
    logic [SAMPLE_BITS-1:0] lv_reg, lv_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic [CW-1:0]          lo_reg, lo_next;
    logic [6:0]             frac_reg, frac_next;
    logic [HALF_BITS-1:0]   val_reg, val_next;

    // shared unit
    tss_alu_req_t           alu_req;
    logic [WIDE_BITS-1:0]   alu_a;
    logic [HALF_BITS-1:0]   alu_b;
    tss_alu_rsp_t           alu_rsp;

    logic [SAMPLE_BITS-1:0] in_sample;
    logic [HALF_BITS-1:0]   sum_ext;
    logic [PW-1:0]          lo_w;
    logic [2*CW-1:0]        count_sq;

    assign in_sample = SAMPLE_BITS'(in_data.sample_value);
    assign sum_ext   = HALF_BITS'(sum_reg) + HALF_BITS'(in_sample);
    assign lo_w      = alu_rsp.result[PCT_RECIP_SHIFT +: PW];
    assign count_sq  = count_reg * count_reg;

    tss_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .opa   (alu_a),
        .opb   (alu_b),
        .rsp   (alu_rsp)
    );

    // store memory
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= store_wdata;
        end
        store_rd_reg <= store_mem[store_raddr];
    end

    // sort buffer
    always_ff @(posedge clk)
    begin
        if (sort_we)
        begin
            sort_mem[sort_waddr] <= sort_wdata;
        end
        sort_rd_reg <= sort_mem[sort_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
            pct_en_reg    <= 1'b1;
            min_reg       <= '1;
            max_reg       <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
            pct_en_reg    <= pct_en_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        q_reg    <= q_next;
        s_reg    <= s_next;
        wide_reg <= wide_next;
        mean_reg <= mean_next;
        std_reg  <= std_next;
        x_reg    <= x_next;
        lv_reg   <= lv_next;
        pos_reg  <= pos_next;
        lo_reg   <= lo_next;
        frac_reg <= frac_next;
        val_reg  <= val_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        out_valid_next = out_valid_reg;
        pct_en_next    = cfg_valid ? cfg_data : pct_en_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_next       = out_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        q_next         = q_reg;
        s_next         = s_reg;
        wide_next      = wide_reg;
        mean_next      = mean_reg;
        std_next       = std_reg;
        x_next         = x_reg;
        lv_next        = lv_reg;
        pos_next       = pos_reg;
        lo_next        = lo_reg;
        frac_next      = frac_reg;
        val_next       = val_reg;
        store_we       = 1'b0;
        store_waddr    = count_reg[AW-1:0];
        store_wdata    = in_sample;
        store_raddr    = idx_reg[AW-1:0];
        sort_we        = 1'b0;
        sort_waddr     = j_reg[AW-1:0];
        sort_wdata     = x_reg;
        sort_raddr     = '0;
        alu_req.start  = 1'b0;
        alu_req.op     = ALU_MUL;
        alu_a          = '0;
        alu_b          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.operation)
                        OP_ADD:
                        begin
                            if (count_reg >= CW'(MAX_SAMPLES))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                if (in_sample < min_reg)
                                begin
                                    min_next = in_sample;
                                end
                                if (in_sample > max_reg)
                                begin
                                    max_next = in_sample;
                                end
                                sum_next   = (sum_ext > HALF_BITS'(TOTAL_MAX)) ?
                                             TOTAL_MAX : sum_ext[TOTAL_BITS-1:0];
                                store_we   = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_REPORT:
                        begin
                            if (count_reg == '0)
                            begin
                                mean_next  = '0;
                                std_next   = '0;
                                state_next = S_SUMMARY;
                            end
                            else
                            begin
                                alu_req.start = 1'b1;
                                alu_req.op    = ALU_DIV;
                                alu_a         = WIDE_BITS'({sum_reg, {FRAC_BITS{1'b0}}});
                                alu_b         = HALF_BITS'(count_reg);
                                state_next    = S_MEAN_WAIT;
                            end
                        end
                        OP_CLEAR:
                        begin
                            min_next   = '1;
                            max_next   = '0;
                            sum_next   = '0;
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MEAN_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    mean_next  = alu_rsp.result[Q_BITS-1:0];
                    idx_next   = '0;
                    q_next     = '0;
                    s_next     = '0;
                    state_next = S_SQ_RD;
                end
            end
            // sum and sum of squares over the store
            S_SQ_RD:
            begin
                state_next = S_SQ_DATA;
            end
            S_SQ_DATA:
            begin
                s_next        = s_reg + HALF_BITS'(store_rd_reg);
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                alu_a         = WIDE_BITS'(store_rd_reg);
                alu_b         = HALF_BITS'(store_rd_reg);
                state_next    = S_SQ_WAIT;
            end
            S_SQ_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    q_next = q_reg + alu_rsp.result;
                    if (CW'(idx_reg + 1'b1) == count_reg)
                    begin
                        state_next = S_NQ_START;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SQ_RD;
                    end
                end
            end
            S_NQ_START:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                alu_a         = q_reg;
                alu_b         = HALF_BITS'(count_reg);
                state_next    = S_NQ_WAIT;
            end
            S_NQ_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    wide_next     = alu_rsp.result;
                    alu_req.start = 1'b1;
                    alu_req.op    = ALU_MUL;
                    alu_a         = WIDE_BITS'(s_reg);
                    alu_b         = s_reg;
                    state_next    = S_SS_WAIT;
                end
            end
            S_SS_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    if (alu_rsp.result > wide_reg)
                    begin
                        std_next   = '0;
                        state_next = S_SUMMARY;
                    end
                    else
                    begin
                        wide_next  = (wide_reg - alu_rsp.result) << (2 * FRAC_BITS);
                        state_next = S_VAR_START;
                    end
                end
            end
            S_VAR_START:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
                alu_a         = wide_reg;
                alu_b         = HALF_BITS'(count_sq);
                state_next    = S_VAR_WAIT;
            end
            S_VAR_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = ALU_SQRT;
                    alu_a         = alu_rsp.result;
                    state_next    = S_SQRT_WAIT;
                end
            end
            S_SQRT_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    std_next   = alu_rsp.result[Q_BITS-1:0];
                    state_next = S_SUMMARY;
                end
            end
            S_SUMMARY:
            begin
                out_next.item_kind        = KIND_SUMMARY;
                out_next.smallest_sample  = 32'(min_reg);
                out_next.largest_sample   = 32'(max_reg);
                out_next.sample_total     = sum_reg;
                out_next.sample_count     = 11'(count_reg);
                out_next.mean_value       = mean_reg;
                out_next.std_dev_value    = std_reg;
                out_next.percentile_slot  = '0;
                out_next.percentile_value = '0;
                out_next.store_overflow   = ovf_reg;
                out_next.last_item        = !(pct_en_reg && (count_reg != '0));
                out_valid_next            = 1'b1;
                idx_next                  = '0;
                ret_next   = (pct_en_reg && (count_reg != '0)) ? S_SORT_RD : S_IDLE;
                state_next = S_EMIT;
            end
            // insertion sort into the sort buffer
            S_SORT_RD:
            begin
                state_next = S_SORT_GET;
            end
            S_SORT_GET:
            begin
                x_next = store_rd_reg;
                j_next = idx_reg;
                if (idx_reg == '0)
                begin
                    sort_we    = 1'b1;
                    sort_waddr = '0;
                    sort_wdata = store_rd_reg;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SORT_NEXT;
                end
                else
                begin
                    sort_raddr = AW'(idx_reg - 1'b1);
                    state_next = S_SORT_CMP;
                end
            end
            S_SORT_CMP:
            begin
                if (sort_rd_reg > x_reg)
                begin
                    sort_we    = 1'b1;
                    sort_wdata = sort_rd_reg;
                    j_next     = j_reg - 1'b1;
                    if (j_reg != CW'(1))
                    begin
                        sort_raddr = AW'(j_reg - CW'(2));
                    end
                    else
                    begin
                        state_next = S_SORT_PUT;
                    end
                end
                else
                begin
                    sort_we    = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SORT_NEXT;
                end
            end
            S_SORT_PUT:
            begin
                sort_we    = 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = S_SORT_NEXT;
            end
            S_SORT_NEXT:
            begin
                if (idx_reg == count_reg)
                begin
                    k_next     = '0;
                    state_next = S_PCT_START;
                end
                else
                begin
                    state_next = S_SORT_RD;
                end
            end
            // interpolated percentiles, divides by 100 as reciprocal multiplies
            S_PCT_START:
            begin
                pos_next      = PW'(pct_target(k_reg)) * PW'(count_reg - 1'b1);
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                alu_a         = WIDE_BITS'(PW'(pct_target(k_reg)) * PW'(count_reg - 1'b1));
                alu_b         = PCT_RECIP;
                state_next    = S_PCT_DIV;
            end
            S_PCT_DIV:
            begin
                if (alu_rsp.done)
                begin
                    lo_next    = CW'(lo_w);
                    frac_next  = 7'(pos_reg - lo_w * PW'(PCT_DENOM));
                    sort_raddr = lo_w[AW-1:0];
                    state_next = S_PCT_RDL;
                end
            end
            S_PCT_RDL:
            begin
                lv_next = sort_rd_reg;
                if (frac_reg == '0)
                begin
                    val_next   = HALF_BITS'(sort_rd_reg) << FRAC_BITS;
                    state_next = S_PCT_EMIT;
                end
                else
                begin
                    sort_raddr = AW'(lo_reg + 1'b1);
                    state_next = S_PCT_RDU;
                end
            end
            // (upper - lower) * frac * 64, then divide by 25
            S_PCT_RDU:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                alu_a         = WIDE_BITS'(sort_rd_reg - lv_reg);
                alu_b         = HALF_BITS'({frac_reg, {INTERP_SHIFT{1'b0}}});
                state_next    = S_PCT_MUL;
            end
            S_PCT_MUL:
            begin
                if (alu_rsp.done)
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = ALU_MUL;
                    alu_a         = alu_rsp.result;
                    alu_b         = INTERP_RECIP;
                    state_next    = S_PCT_DIV2;
                end
            end
            S_PCT_DIV2:
            begin
                if (alu_rsp.done)
                begin
                    val_next   = (HALF_BITS'(lv_reg) << FRAC_BITS) +
                                 alu_rsp.result[WIDE_BITS-1:HALF_BITS];
                    state_next = S_PCT_EMIT;
                end
            end
            S_PCT_EMIT:
            begin
                out_next                  = '0;
                out_next.item_kind        = KIND_PERCENTILE;
                out_next.percentile_slot  = k_reg;
                out_next.percentile_value = val_reg[Q_BITS-1:0];
                out_next.store_overflow   = ovf_reg;
                out_next.last_item        = (k_reg == 3'(PCT_COUNT - 1));
                out_valid_next            = 1'b1;
                k_next                    = k_reg + 1'b1;
                ret_next   = (k_reg == 3'(PCT_COUNT - 1)) ? S_IDLE : S_PCT_START;
                state_next = S_EMIT;
            end
            // hold a result until taken
            S_EMIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    // checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request accepted while a result is pending");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SAMPLES))
        else $error("sample count past store depth");
    a_pct_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.item_kind == KIND_PERCENTILE) |-> pct_en_reg)
        else $error("percentile item while percentiles disabled");
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.item_kind == KIND_SUMMARY && out_data.sample_count == '0)
        |-> out_data.last_item)
        else $error("empty summary not marked last");

endmodule
